FILE: rtl/core/lcnco_pkg.sv
package lcnco_pkg;

    // Configuration port geometry
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_PHASE_START = 3'd0;
    localparam logic [2:0] REG_FREQ_START  = 3'd1;
    localparam logic [2:0] REG_CHIRP_RATE  = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE   = 3'd3;
    localparam logic [2:0] REG_WAVE_MODE   = 3'd4;

    // Wave modes; the spare code decodes like complex
    localparam logic [1:0] MODE_COS       = 2'd0;
    localparam logic [1:0] MODE_SIN       = 2'd1;
    localparam logic [1:0] MODE_CPLX      = 2'd2;
    localparam logic [1:0] MODE_CPLX_ALT  = 2'd3;

    localparam int AMP_W = 16;
    localparam int MAG_W = 31;

    // Register file contents as seen by the datapath
    typedef struct packed {
        logic [31:0]      phase_start;
        logic [31:0]      freq_start;
        logic [31:0]      chirp_rate;
        logic [AMP_W-1:0] amplitude;
        logic [1:0]       wave_mode;
    } t_cfg;

    // Quarter-wave sine generator constants (Q30)
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // Sine of u/2^frac_sh quarter turns in Q30, nested Taylor form; elaboration use only
    function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] u,
                                                      input int unsigned frac_sh);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (u * HALF_PI_Q30) >> frac_sh;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int i = 0; i < 6; i++) begin
            t = ONE_Q30 - (((x2 * t) >> 30) / TAYLOR_DIV[i]);
        end
        return MAG_W'((x * t) >> 30);
    endfunction

endpackage

FILE: rtl/core/linear_chirp_nco.sv
// Linear chirp oscillator. Each request pushed in is one sample tick and yields
// exactly one sample request out, in order: the phase accumulator adds the current
// increment, the increment adds the chirp rate, and amplitude times cosine and/or
// sine of the new phase comes out as saturated signed Q1.(OUT_BITS-1) values.
// restart reloads phase and increment from phase_start/freq_start before the tick.
// Throughput is one sample per clock while the result queue has room: the front
// updates both accumulators as it accepts a tick, and the wave back end is a
// three-stage pipeline (fold, quarter-wave table read, amplitude multiply) with
// rounding on its output. A tick waits in the 4-entry tick queue, passes the fold,
// table read and multiply registers, and its sample is then written to the result
// queue, which clears empty. The 8-entry result queue absorbs pop stalls; the tick
// queue fills and full rises once both queues back up. Registers are to be written
// only when the block is drained.
module linear_chirp_nco #(
    parameter int PHASE_BITS      = 32,
    parameter int OUT_BITS        = 16,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcnco_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lcnco_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lcnco_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_restart,
    input  logic                                i_last_tick,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [OUT_BITS-1:0]          o_sample_real,
    output logic signed [OUT_BITS-1:0]          o_sample_imag,
    output logic                                o_last_out
);
    import lcnco_pkg::*;

    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;
    localparam int MID_W     = TABLE_ADDR_BITS + 1;
    localparam int RES_W     = 2 * OUT_BITS + 1;

    t_cfg                        cfg;
    logic                        mid_push, mid_full, mid_pop, mid_empty;
    logic [MID_W-1:0]            mid_wdata, mid_rdata;
    logic [$clog2(MID_DEPTH):0]  mid_level;
    logic                        out_wr, out_full;
    logic [RES_W-1:0]            out_wdata, out_rdata;
    logic [$clog2(OUT_DEPTH):0]  out_level;

    lcnco_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcnco_front #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .i_restart   (i_restart),
        .i_last_tick (i_last_tick),
        .o_full      (full),
        .o_q_push    (mid_push),
        .o_q_data    (mid_wdata),
        .i_q_full    (mid_full)
    );

    // Tick queue between front and wave pipeline
    lcnco_queue #(
        .W     (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_rdata),
        .o_level (mid_level)
    );

    lcnco_wave #(
        .OUT_BITS        (OUT_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .OUT_DEPTH       (OUT_DEPTH)
    ) u_wave (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (mid_empty),
        .i_q_data    (mid_rdata),
        .o_q_pop     (mid_pop),
        .i_out_level (out_level),
        .o_wr_valid  (out_wr),
        .o_wr_data   (out_wdata)
    );

    // Result queue
    lcnco_queue #(
        .W     (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_wr),
        .i_data  (out_wdata),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_rdata),
        .o_level (out_level)
    );

    assign o_sample_real = out_rdata[RES_W-1 -: OUT_BITS];
    assign o_sample_imag = out_rdata[OUT_BITS:1];
    assign o_last_out    = out_rdata[0];

    // Credit check must keep the result queue from overflowing
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_wr |-> !out_full)
        else $error("result write while result queue full");

    // Every tick leaving the tick queue lands in the result queue after the fold, table read and multiply registers
    a_pipe_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_pop |-> ##3 out_wr)
        else $error("wave pipeline lost a sample");

    // An accepted tick is held in the tick queue on the next edge
    a_tick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> (!mid_empty && (mid_level != '0)))
        else $error("accepted tick not queued");

endmodule

FILE: rtl/core/lcnco_queue.sv
module lcnco_queue #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [W-1:0]             i_data,
    output logic                     o_full,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic [W-1:0]             o_data,
    output logic [$clog2(DEPTH):0]   o_level
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW:0]   r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_level = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_pop && !o_empty;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = wr_en ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = rd_en ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: rtl/core/lcnco_regs.sv
module lcnco_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lcnco_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [lcnco_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [lcnco_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output lcnco_pkg::t_cfg                     o_cfg
);
    import lcnco_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_start <= '0;
            r_cfg.freq_start  <= '0;
            r_cfg.chirp_rate  <= '0;
            r_cfg.amplitude   <= '0;
            r_cfg.wave_mode   <= MODE_CPLX;
        end else if (wr_en) begin
            case (idx)
                REG_PHASE_START: r_cfg.phase_start <= pwdata;
                REG_FREQ_START:  r_cfg.freq_start  <= pwdata;
                REG_CHIRP_RATE:  r_cfg.chirp_rate  <= pwdata;
                REG_AMPLITUDE:   r_cfg.amplitude   <= pwdata[AMP_W-1:0];
                REG_WAVE_MODE:   r_cfg.wave_mode   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        case (idx)
            REG_PHASE_START: prdata = r_cfg.phase_start;
            REG_FREQ_START:  prdata = r_cfg.freq_start;
            REG_CHIRP_RATE:  prdata = r_cfg.chirp_rate;
            REG_AMPLITUDE:   prdata = CFG_DATA_W'(r_cfg.amplitude);
            REG_WAVE_MODE:   prdata = CFG_DATA_W'(r_cfg.wave_mode);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/lcnco_front.sv
module lcnco_front #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lcnco_pkg::t_cfg             i_cfg,
    input  logic                        i_push,
    input  logic                        i_restart,
    input  logic                        i_last_tick,
    output logic                        o_full,
    output logic                        o_q_push,
    output logic [TABLE_ADDR_BITS:0]    o_q_data,
    input  logic                        i_q_full
);
    import lcnco_pkg::*;

    logic [PHASE_BITS-1:0] r_acc, n_acc;
    logic [PHASE_BITS-1:0] r_step, n_step;
    logic [PHASE_BITS-1:0] a_ps, a_fs, a_cr;
    logic [PHASE_BITS-1:0] base_acc, base_step;
    logic                  accept;

    // Register values aligned to the accumulator MSB
    if (PHASE_BITS > 32) begin : g_up
        assign a_ps = {i_cfg.phase_start, {(PHASE_BITS-32){1'b0}}};
        assign a_fs = {i_cfg.freq_start,  {(PHASE_BITS-32){1'b0}}};
        assign a_cr = {i_cfg.chirp_rate,  {(PHASE_BITS-32){1'b0}}};
    end else if (PHASE_BITS == 32) begin : g_eq
        assign a_ps = i_cfg.phase_start;
        assign a_fs = i_cfg.freq_start;
        assign a_cr = i_cfg.chirp_rate;
    end else begin : g_dn
        assign a_ps = i_cfg.phase_start[31 -: PHASE_BITS];
        assign a_fs = i_cfg.freq_start[31 -: PHASE_BITS];
        assign a_cr = i_cfg.chirp_rate[31 -: PHASE_BITS];
    end

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    // Phase and increment update, restart reloads first
    always_comb begin
        base_acc  = i_restart ? a_ps : r_acc;
        base_step = i_restart ? a_fs : r_step;
        n_acc     = base_acc + base_step;
        n_step    = base_step + a_cr;
    end

    // Table address of the new phase plus the block-end mark
    assign o_q_data = {n_acc[PHASE_BITS-1 -: TABLE_ADDR_BITS], i_last_tick};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_step <= '0;
        end else if (accept) begin
            r_acc  <= n_acc;
            r_step <= n_step;
        end
    end

endmodule

FILE: rtl/core/lcnco_wave.sv
module lcnco_wave #(
    parameter int OUT_BITS        = 16,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int OUT_DEPTH       = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lcnco_pkg::t_cfg                 i_cfg,
    input  logic                            i_q_empty,
    input  logic [TABLE_ADDR_BITS:0]        i_q_data,
    output logic                            o_q_pop,
    input  logic [$clog2(OUT_DEPTH):0]      i_out_level,
    output logic                            o_wr_valid,
    output logic [2*OUT_BITS:0]             o_wr_data
);
    import lcnco_pkg::*;

    localparam int AB    = TABLE_ADDR_BITS;
    localparam int QTR   = 1 << (AB - 2);
    localparam int UW    = AB - 1;
    localparam int LW    = $clog2(OUT_DEPTH) + 2;
    localparam int PW    = AMP_W + MAG_W;
    localparam int SH    = 46 - OUT_BITS;
    localparam int RW    = PW - SH;
    localparam logic [RW-1:0] LIM_POS = RW'((64'd1 << (OUT_BITS - 1)) - 64'd1);
    localparam logic [RW-1:0] LIM_NEG = RW'(64'd1 << (OUT_BITS - 1));
    localparam logic [PW-1:0] BIAS    = PW'(64'd1 << (SH - 1));

    // Quarter-wave table, u = 0 .. QTR inclusive
    logic [MAG_W-1:0] rom [QTR+1];
    for (genvar g = 0; g <= QTR; g++) begin : g_rom
        localparam logic [MAG_W-1:0] V = quarter_sine(64'(g), AB - 2);
        assign rom[g] = V;
    end

    // Fold a table address into {negate, quarter argument}
    function automatic logic [UW:0] fold(input logic [AB-1:0] k);
        logic [1:0]    q;
        logic [UW-1:0] r;
        logic [UW-1:0] u;
        q = k[AB-1:AB-2];
        r = {1'b0, k[AB-3:0]};
        u = q[0] ? UW'(QTR) - r : r;
        return {q[1], u};
    endfunction

    // Round half away from zero, sign, saturate
    function automatic logic [OUT_BITS-1:0] scale(input logic [PW-1:0] prod,
                                                   input logic neg);
        logic [PW-1:0] sum;
        logic [RW-1:0] rnd;
        logic [RW-1:0] neg_rnd;
        sum = prod + BIAS;
        rnd = sum[PW-1:SH];
        if (neg) begin
            if (rnd > LIM_NEG) rnd = LIM_NEG;
            neg_rnd = RW'(0) - rnd;
            return neg_rnd[OUT_BITS-1:0];
        end
        if (rnd > LIM_POS) rnd = LIM_POS;
        return rnd[OUT_BITS-1:0];
    endfunction

    logic [AB-1:0]    k_s, k_c;
    logic [UW:0]      f_s, f_c;
    logic             issue;
    logic [1:0]       inflight;

    logic             r1_v, r1_neg_s, r1_neg_c, r1_last;
    logic [UW-1:0]    r1_u_s, r1_u_c;
    logic             r2_v, r2_neg_s, r2_neg_c, r2_last;
    logic [MAG_W-1:0] r2_mag_s, r2_mag_c;
    logic             r3_v, r3_neg_s, r3_neg_c, r3_last;
    logic [PW-1:0]    r3_prod_s, r3_prod_c;

    logic [OUT_BITS-1:0] smp_s, smp_c, smp_re, smp_im;
    logic                sin_only, cplx;

    // Issue only with a guaranteed slot in the result queue
    assign inflight = 2'(r1_v) + 2'(r2_v) + 2'(r3_v);
    assign issue    = !i_q_empty &&
                      ((LW'(i_out_level) + LW'(inflight)) < LW'(OUT_DEPTH));
    assign o_q_pop  = issue;

    assign k_s = i_q_data[AB:1];
    assign k_c = k_s + AB'(QTR);
    assign f_s = fold(k_s);
    assign f_c = fold(k_c);

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= issue;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // Fold, table read, multiply
    always_ff @(posedge i_clk) begin
        r1_u_s    <= f_s[UW-1:0];
        r1_neg_s  <= f_s[UW];
        r1_u_c    <= f_c[UW-1:0];
        r1_neg_c  <= f_c[UW];
        r1_last   <= i_q_data[0];

        r2_mag_s  <= rom[r1_u_s];
        r2_mag_c  <= rom[r1_u_c];
        r2_neg_s  <= r1_neg_s;
        r2_neg_c  <= r1_neg_c;
        r2_last   <= r1_last;

        r3_prod_s <= PW'(i_cfg.amplitude) * PW'(r2_mag_s);
        r3_prod_c <= PW'(i_cfg.amplitude) * PW'(r2_mag_c);
        r3_neg_s  <= r2_neg_s;
        r3_neg_c  <= r2_neg_c;
        r3_last   <= r2_last;
    end

    // Output scaling and mode select
    always_comb begin
        smp_s    = scale(r3_prod_s, r3_neg_s);
        smp_c    = scale(r3_prod_c, r3_neg_c);
        sin_only = (i_cfg.wave_mode == MODE_SIN);
        cplx     = i_cfg.wave_mode inside {MODE_CPLX, MODE_CPLX_ALT};
        smp_re   = sin_only ? smp_s : smp_c;
        smp_im   = cplx ? smp_s : '0;
    end

    assign o_wr_valid = r3_v;
    assign o_wr_data  = {smp_re, smp_im, r3_last};

endmodule
